### rtl/core/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// Shared constants, codes and types of the indexed shift list.
// ----------------------------------------------------------------------------
package isl_pkg;

   localparam int DEPTH   = 16;
   localparam int WIDTH   = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FUNC_W  = 3;
   localparam int STAT_W  = 2;

   localparam int REQ_BITS = FUNC_W + IDX_W + WIDTH;
   localparam int RSP_BITS = WIDTH + CNT_W + STAT_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   typedef logic [DEPTH-1:0][WIDTH-1:0] word_array_type;

   typedef struct packed {
      logic              load;
      logic              ins;
      logic              del;
      logic [IDX_W-1:0]  target;
      logic [WIDTH-1:0]  value;
   } cell_cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  count;
      logic [WIDTH-1:0]  read_data;
   } rsp_type;

endpackage

### rtl/core/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell
// One list slot: loads, shifts up from below or down from above.
// ----------------------------------------------------------------------------
module isl_cell (
   input  logic                       clock,
   input  isl_pkg::cell_cmd_type      cmd,
   input  logic [isl_pkg::IDX_W-1:0]  cell_pos,
   input  logic [isl_pkg::WIDTH-1:0]  below_data,
   input  logic [isl_pkg::WIDTH-1:0]  above_data,
   output logic [isl_pkg::WIDTH-1:0]  cell_data
);
   import isl_pkg::*;

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.load && cell_pos == cmd.target) begin
         data_in = cmd.value;
      end else if (cmd.ins) begin
         if (cell_pos == cmd.target) begin
            data_in = cmd.value;
         end else if (cell_pos > cmd.target) begin
            data_in = below_data;
         end
      end else if (cmd.del && cell_pos >= cmd.target) begin
         data_in = above_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

### rtl/core/isl_ctrl.sv
// ----------------------------------------------------------------------------
// isl_ctrl
// Operation decode, fill count and read selection for the cell row.
// ----------------------------------------------------------------------------
module isl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [isl_pkg::FUNC_W-1:0]  func,
   input  logic [isl_pkg::IDX_W-1:0]   index,
   input  logic [isl_pkg::WIDTH-1:0]   value,
   input  isl_pkg::word_array_type     cell_words,
   output isl_pkg::cell_cmd_type       cmd,
   output isl_pkg::rsp_type            rsp
);
   import isl_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_new;
   logic [CNT_W-1:0] idx_ext;
   logic             idx_lt;
   logic             full;
   logic             del_ok;

   assign idx_ext = CNT_W'(index);
   assign idx_lt  = idx_ext < count_ff;
   assign full    = count_ff == CNT_W'(DEPTH);

   always_comb begin
      cmd           = '0;
      cmd.value     = value;
      cmd.target    = index;
      rsp.read_data = '0;
      rsp.status    = ST_OK;
      count_new     = count_ff;
      del_ok        = 1'b0;
      case (func)
         FUNC_READ: begin
            if (idx_lt) begin
               rsp.read_data = cell_words[index];
            end else begin
               rsp.status = ST_BAD;
            end
         end
         FUNC_APPEND: begin
            if (full) begin
               rsp.status = ST_FULL;
            end else begin
               cmd.load   = accept;
               cmd.target = count_ff[IDX_W-1:0];
               count_new  = count_ff + CNT_W'(1);
            end
         end
         FUNC_WRITE: begin
            if (idx_lt) begin
               cmd.load = accept;
            end else begin
               rsp.status = ST_BAD;
            end
         end
         FUNC_INSERT: begin
            if (count_ff == '0 || idx_ext > count_ff) begin
               rsp.status = ST_BAD;
            end else if (full) begin
               rsp.status = ST_FULL;
            end else begin
               cmd.ins   = accept;
               count_new = count_ff + CNT_W'(1);
            end
         end
         FUNC_DELETE: begin
            if (idx_lt) begin
               cmd.del   = accept;
               del_ok    = 1'b1;
               count_new = count_ff - CNT_W'(1);
            end else begin
               rsp.status = ST_BAD;
            end
         end
         default: begin
         end
      endcase
      rsp.count = count_new;
      count_in  = accept ? count_new : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above capacity");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (accept && del_ok) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not lower count");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count moved without transaction");

endmodule

### rtl/core/indexed_shift_list_top.sv
// ----------------------------------------------------------------------------
// indexed_shift_list_top
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel  direction  payload (low bit first)
//  req_     in         func[2:0] index[6:3] value[38:7] zero[39]
//  rsp_     out        read_data[31:0] count[36:32] status[38:37] zero[39]
//
//  One transaction per clock while req_tready is high; all cells shift,
//  load or hold in the same cycle, and the result is registered for rsp_.
//  A two-entry output buffer takes one more transaction while rsp_ stalls.
//  Synchronous reset empties the list and the output buffer.
// ----------------------------------------------------------------------------
module indexed_shift_list_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [isl_pkg::REQ_TDATA_W-1:0]   req_tdata,  // func, index, value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [isl_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // read_data, count, status
);
   import isl_pkg::*;

   logic [FUNC_W-1:0] func;
   logic [IDX_W-1:0]  index;
   logic [WIDTH-1:0]  value;
   logic              req_accept;
   logic              rsp_take;
   cell_cmd_type      cmd;
   rsp_type           rsp_new;
   word_array_type    cell_words;

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_ff;
   rsp_type out_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;

   assign func  = req_tdata[FUNC_W-1:0];
   assign index = req_tdata[FUNC_W+IDX_W-1:FUNC_W];
   assign value = req_tdata[REQ_BITS-1:FUNC_W+IDX_W];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   isl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .func       (func),
      .index      (index),
      .value      (value),
      .cell_words (cell_words),
      .cmd        (cmd),
      .rsp        (rsp_new)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] below;
      logic [WIDTH-1:0] above;
      if (i == 0) begin : g_first
         assign below = value;
      end else begin : g_mid_lo
         assign below = cell_words[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign above = cell_words[i];
      end else begin : g_mid_hi
         assign above = cell_words[i+1];
      end
      isl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_pos   (IDX_W'(i)),
         .below_data (below),
         .above_data (above),
         .cell_data  (cell_words[i])
      );
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = rsp_new;
            out_valid_in = req_accept;
         end
      end else if (req_accept) begin
         skid_in       = rsp_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_ff);

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output entry");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> out_valid_ff)
      else $error("accepted transaction left no result");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_take) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved forward");

endmodule
